// ===== hw/rtl/gcfp_pkg.sv =====
// Shared types and constants for the grid cell first point sampler.
// No dependencies.
package gcfp_pkg;

  localparam logic [31:0] MIN_INIT = 32'h7FFF_FFFF;
  localparam logic [31:0] MAX_INIT = 32'h8000_0000;
  localparam logic [30:0] RES_INIT = 31'd65536;
  localparam int          PNUM_W   = 12;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  typedef struct packed {
    logic [31:0] min_x;
    logic [31:0] max_x;
    logic [31:0] min_y;
    logic [31:0] max_y;
  } box_t;

endpackage

// ===== hw/rtl/gcfp_front.sv =====
// Front end: accepts points, writes the point store, tracks the x/y box
// and hands a closed cloud to the back end. Uses gcfp_pkg.
module gcfp_front #(
  parameter int MAX_POINTS = 4096,
  parameter int AW         = 12,
  parameter int CNT_W      = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic signed [31:0]   in_coord_x,
  input  logic signed [31:0]   in_coord_y,
  input  logic signed [31:0]   in_coord_z,
  input  logic                 in_last_point,
  input  logic                 back_busy,
  output logic                 cmd_valid,
  input  logic                 cmd_take,
  output gcfp_pkg::box_t       cmd_box,
  output logic [CNT_W-1:0]     cmd_count,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output gcfp_pkg::point_t     wr_pt
);

  gcfp_pkg::box_t   box_r, box_nxt, cmd_box_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cmd_cnt_r;
  logic             cmd_valid_r;
  logic             accept, room;

  assign in_full = cmd_valid_r || back_busy;
  assign accept  = in_push && !in_full;
  assign room    = cnt_r < CNT_W'(MAX_POINTS);
  assign wr_en   = accept && room;
  assign wr_addr = cnt_r[AW-1:0];
  assign wr_pt   = '{x: in_coord_x, y: in_coord_y, z: in_coord_z};

  always_comb begin
    box_nxt = box_r;
    cnt_nxt = cnt_r;
    if (wr_en) begin
      if (in_coord_x < $signed(box_r.min_x)) box_nxt.min_x = in_coord_x;
      if (in_coord_x > $signed(box_r.max_x)) box_nxt.max_x = in_coord_x;
      if (in_coord_y < $signed(box_r.min_y)) box_nxt.min_y = in_coord_y;
      if (in_coord_y > $signed(box_r.max_y)) box_nxt.max_y = in_coord_y;
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r       <= '{gcfp_pkg::MIN_INIT, gcfp_pkg::MAX_INIT,
                       gcfp_pkg::MIN_INIT, gcfp_pkg::MAX_INIT};
      cnt_r       <= '0;
      cmd_valid_r <= 1'b0;
    end else begin
      if (cmd_take) cmd_valid_r <= 1'b0;
      if (accept && in_last_point) begin
        cmd_valid_r <= 1'b1;
        box_r       <= '{gcfp_pkg::MIN_INIT, gcfp_pkg::MAX_INIT,
                         gcfp_pkg::MIN_INIT, gcfp_pkg::MAX_INIT};
        cnt_r       <= '0;
      end else begin
        box_r <= box_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_last_point) begin
      cmd_box_r <= box_nxt;
      cmd_cnt_r <= cnt_nxt;
    end
  end

  assign cmd_valid = cmd_valid_r;
  assign cmd_box   = cmd_box_r;
  assign cmd_count = cmd_cnt_r;

endmodule

// ===== hw/rtl/gcfp_back.sv =====
// Back end: point store, grid count, binning pass and keypoint emission
// through a one-entry output register. Uses gcfp_pkg.
module gcfp_back #(
  parameter int MAX_POINTS = 4096,
  parameter int GRID_SIDE  = 8,
  parameter int AW         = 12,
  parameter int CNT_W      = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [30:0]          grid_resolution,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  gcfp_pkg::point_t     wr_pt,
  input  logic                 cmd_valid,
  output logic                 cmd_take,
  input  gcfp_pkg::box_t       cmd_box,
  input  logic [CNT_W-1:0]     cmd_count,
  output logic                 busy,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [11:0]          out_point_number,
  output logic signed [31:0]   out_x,
  output logic signed [31:0]   out_y,
  output logic signed [31:0]   out_z,
  output logic                 out_last_keypoint
);

  localparam int GW    = $clog2(GRID_SIDE + 1);
  localparam int SW    = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int KW    = $clog2(CELLS + 1);
  localparam int PW    = 32 + GW;
  localparam int DW    = 35 + GW;

  typedef enum logic [2:0] {
    S_IDLE, S_COUNT, S_PREP, S_BIN, S_CHK, S_IDX, S_OUT
  } state_t;

  state_t state_r;

  gcfp_pkg::point_t mem_x_pt;
  logic [31:0] mem_x [MAX_POINTS];
  logic [31:0] mem_y [MAX_POINTS];
  logic [31:0] mem_z [MAX_POINTS];
  logic [AW-1:0] fidx_mem [CELLS];
  logic [AW-1:0] rd_addr, fidx_rd_r;
  gcfp_pkg::point_t rd_pt_r;

  gcfp_pkg::box_t   box_r;
  logic [CNT_W-1:0] npts_r, pi_r;
  logic [31:0]      ext_x_r, ext_y_r;
  logic [34:0]      div_r;
  logic [DW-1:0]    accd_r, accd_nxt;
  logic [PW-1:0]    accx_r, accy_r, accx_nxt, accy_nxt;
  logic [PW-1:0]    mx_r [GRID_SIDE];
  logic [PW-1:0]    my_r [GRID_SIDE];
  logic [GW-1:0]    m_r, n_r;
  logic [SW-1:0]    step_r;

  logic             v1_r, v2_r, v3_r;
  logic [AW-1:0]    p1_r, p2_r, p3_r;
  logic [31:0]      offx_c, offy_c;
  logic [PW-1:0]    prodx_r, prody_r;
  logic [GW-1:0]    ix_r, iy_r, ix_c, iy_c;
  logic [CW-1:0]    cell_c, lastcell_r;
  logic [CELLS-1:0] occ_r;
  logic [KW-1:0]    k_r, mn;
  logic             fidx_we;

  logic             out_valid_r, out_last_r;
  logic [11:0]      out_pnum_r;
  gcfp_pkg::point_t out_pt_r;

  assign busy     = state_r != S_IDLE;
  assign cmd_take = (state_r == S_IDLE) && cmd_valid;
  assign rd_addr  = (state_r == S_BIN) ? pi_r[AW-1:0] : fidx_rd_r;
  assign mn       = KW'(m_r * n_r);
  assign cell_c   = CW'(iy_r * m_r + ix_r);
  assign fidx_we  = v3_r && !occ_r[cell_c];
  assign accd_nxt = accd_r + DW'(div_r);
  assign accx_nxt = accx_r + PW'(ext_x_r);
  assign accy_nxt = accy_r + PW'(ext_y_r);
  assign mem_x_pt = wr_pt;
  assign offx_c   = rd_pt_r.x - box_r.min_x;
  assign offy_c   = rd_pt_r.y - box_r.min_y;

  // point store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= mem_x_pt.x;
      mem_y[wr_addr] <= mem_x_pt.y;
      mem_z[wr_addr] <= mem_x_pt.z;
    end
    rd_pt_r <= '{x: mem_x[rd_addr], y: mem_y[rd_addr], z: mem_z[rd_addr]};
  end

  // first point index per cell
  always_ff @(posedge clk) begin
    if (fidx_we) fidx_mem[cell_c] <= p3_r;
    fidx_rd_r <= fidx_mem[k_r[CW-1:0]];
  end

  // bin index: number of multiples of the extent at or below offset*count
  always_comb begin
    ix_c = '0;
    iy_c = '0;
    for (int k = 1; k <= GRID_SIDE; k++) begin
      if (GW'(k) <= m_r && prodx_r >= mx_r[k-1]) ix_c = ix_c + 1'b1;
      if (GW'(k) <= n_r && prody_r >= my_r[k-1]) iy_c = iy_c + 1'b1;
    end
    if (ix_c >= m_r) ix_c = m_r - 1'b1;
    if (iy_c >= n_r) iy_c = n_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    prodx_r <= PW'(offx_c) * PW'(m_r);
    prody_r <= PW'(offy_c) * PW'(n_r);
    ix_r    <= ix_c;
    iy_r    <= iy_c;
    p1_r    <= pi_r[AW-1:0];
    p2_r    <= p1_r;
    p3_r    <= p2_r;
    if (state_r == S_COUNT) begin
      mx_r[step_r] <= accx_nxt;
      my_r[step_r] <= accy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      occ_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
    end else begin
      if (out_pop && out_valid_r) out_valid_r <= 1'b0;
      v1_r <= (state_r == S_BIN) && (pi_r < npts_r);
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (v3_r) begin
        occ_r[cell_c] <= 1'b1;
        if (cell_c > lastcell_r) lastcell_r <= cell_c;
      end
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            box_r   <= cmd_box;
            npts_r  <= cmd_count;
            ext_x_r <= cmd_box.max_x - cmd_box.min_x;
            ext_y_r <= cmd_box.max_y - cmd_box.min_y;
            div_r   <= {1'b0, grid_resolution, 3'b000} + {3'b000, grid_resolution, 1'b0};
            accd_r  <= '0;
            accx_r  <= '0;
            accy_r  <= '0;
            m_r     <= '0;
            n_r     <= '0;
            step_r  <= '0;
            state_r <= S_COUNT;
          end
        end
        S_COUNT: begin
          accd_r <= accd_nxt;
          accx_r <= accx_nxt;
          accy_r <= accy_nxt;
          if (accd_nxt <= DW'(ext_x_r) && ext_x_r != '0) m_r <= GW'(step_r) + 1'b1;
          if (accd_nxt <= DW'(ext_y_r) && ext_y_r != '0) n_r <= GW'(step_r) + 1'b1;
          step_r <= step_r + 1'b1;
          if (step_r == SW'(GRID_SIDE - 1)) state_r <= S_PREP;
        end
        S_PREP: begin
          occ_r      <= '0;
          lastcell_r <= '0;
          pi_r       <= '0;
          state_r    <= (m_r == '0 || n_r == '0) ? S_IDLE : S_BIN;
        end
        S_BIN: begin
          if (pi_r < npts_r) begin
            pi_r <= pi_r + 1'b1;
          end else if (!v1_r && !v2_r && !v3_r) begin
            k_r     <= '0;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (k_r == mn) begin
            state_r <= S_IDLE;
          end else if (occ_r[k_r[CW-1:0]]) begin
            state_r <= S_IDX;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_IDX: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_pop) begin
            out_valid_r <= 1'b1;
            out_pnum_r  <= 12'(fidx_rd_r);
            out_pt_r    <= rd_pt_r;
            out_last_r  <= k_r[CW-1:0] == lastcell_r;
            k_r         <= k_r + 1'b1;
            state_r     <= S_CHK;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_point_number  = out_pnum_r;
  assign out_x             = out_pt_r.x;
  assign out_y             = out_pt_r.y;
  assign out_z             = out_pt_r.z;
  assign out_last_keypoint = out_last_r;

endmodule

// ===== hw/rtl/grid_cell_first_point_sampler.sv =====
// Loading: one point per cycle while in_full is low. After the last point come the grid count,
// a prep step, the binning pass over the points, then a check of every cell and a read of
// each emitted keypoint (held while the output is not popped), and a closing step. No point
// is taken meanwhile.
// Reset (rst_n low, synchronous) clears control state and sets grid_resolution to 1.0;
// the point store and cell index store hold no reset value.
module grid_cell_first_point_sampler #(
  parameter int MAX_POINTS = 4096,
  parameter int GRID_SIDE  = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic signed [31:0]  in_coord_x,
  input  logic signed [31:0]  in_coord_y,
  input  logic signed [31:0]  in_coord_z,
  input  logic                in_last_point,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [11:0]         out_point_number,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic                out_last_keypoint,
  input  logic                cfg_we,
  input  logic [30:0]         cfg_wdata
);

  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic [30:0]      res_r;
  logic             back_busy, cmd_valid, cmd_take, wr_en;
  gcfp_pkg::box_t   cmd_box;
  logic [CNT_W-1:0] cmd_count;
  logic [AW-1:0]    wr_addr;
  gcfp_pkg::point_t wr_pt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= gcfp_pkg::RES_INIT;
    end else if (cfg_we) begin
      res_r <= cfg_wdata;
    end
  end

  gcfp_front #(.MAX_POINTS(MAX_POINTS), .AW(AW), .CNT_W(CNT_W)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .in_last_point(in_last_point),
    .back_busy(back_busy), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .cmd_box(cmd_box), .cmd_count(cmd_count),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_pt(wr_pt)
  );

  gcfp_back #(.MAX_POINTS(MAX_POINTS), .GRID_SIDE(GRID_SIDE), .AW(AW), .CNT_W(CNT_W))
    u_back (
    .clk(clk), .rst_n(rst_n), .grid_resolution(res_r),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_pt(wr_pt),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd_box(cmd_box), .cmd_count(cmd_count),
    .busy(back_busy),
    .out_empty(out_empty), .out_pop(out_pop), .out_point_number(out_point_number),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_last_keypoint(out_last_keypoint)
  );

endmodule

// ===== dv/grid_cell_first_point_sampler_tb.sv =====
`timescale 1ns / 1ps
// Testbench for grid_cell_first_point_sampler: streams point clouds and checks
// every emitted keypoint against a behavioral grid binning predictor.
// Depends on gcfp_pkg and the grid_cell_first_point_sampler RTL.

class keypoint_board;
  typedef struct {
    bit [11:0] num;
    bit [31:0] x;
    bit [31:0] y;
    bit [31:0] z;
    bit        last;
  } keypoint_t;

  bit [31:0]   pt_x[4096];
  bit [31:0]   pt_y[4096];
  bit [31:0]   pt_z[4096];
  int unsigned loaded;
  bit [31:0]   lo_x, hi_x, lo_y, hi_y;
  bit [30:0]   res;
  keypoint_t   pending[$];
  int          errors;

  function new();
    res = gcfp_pkg::RES_INIT;
    start_cloud();
  endfunction

  function void start_cloud();
    loaded = 0;
    lo_x = gcfp_pkg::MIN_INIT;
    lo_y = gcfp_pkg::MIN_INIT;
    hi_x = gcfp_pkg::MAX_INIT;
    hi_y = gcfp_pkg::MAX_INIT;
  endfunction

  function longint unsigned grid_count(longint unsigned ext);
    longint unsigned q;
    if (ext == 0) return 0;
    if (res == 0) return 8;
    q = ext / (64'(res) * 10);
    return (q > 8) ? 8 : q;
  endfunction

  function longint unsigned bin_of(longint unsigned off, longint unsigned cnt,
                                   longint unsigned ext);
    longint unsigned k;
    k = off * cnt / ext;
    return (k >= cnt) ? cnt - 1 : k;
  endfunction

  function void note_point(bit [31:0] x, bit [31:0] y, bit [31:0] z, bit last);
    longint unsigned ex, ey, m, n, i, j, c;
    bit [63:0]       occ;
    int unsigned     first[64];
    keypoint_t       kp;
    int              idx_last;
    if (loaded < 4096) begin
      pt_x[loaded] = x;
      pt_y[loaded] = y;
      pt_z[loaded] = z;
      if ($signed(x) < $signed(lo_x)) lo_x = x;
      if ($signed(x) > $signed(hi_x)) hi_x = x;
      if ($signed(y) < $signed(lo_y)) lo_y = y;
      if ($signed(y) > $signed(hi_y)) hi_y = y;
      loaded++;
    end
    if (!last) return;
    ex = 64'(hi_x ^ 32'h8000_0000) - 64'(lo_x ^ 32'h8000_0000);
    ey = 64'(hi_y ^ 32'h8000_0000) - 64'(lo_y ^ 32'h8000_0000);
    m = grid_count(ex);
    n = grid_count(ey);
    occ = '0;
    idx_last = -1;
    if (m != 0 && n != 0) begin
      for (int p = 0; p < loaded; p++) begin
        i = bin_of(64'(pt_x[p] ^ 32'h8000_0000) - 64'(lo_x ^ 32'h8000_0000), m, ex);
        j = bin_of(64'(pt_y[p] ^ 32'h8000_0000) - 64'(lo_y ^ 32'h8000_0000), n, ey);
        c = (j * m + i) % 64;
        if (!occ[c]) begin
          occ[c] = 1'b1;
          first[c] = p;
        end
      end
      for (int k = 0; k < m * n; k++) begin
        if (occ[k]) begin
          kp.num  = first[k][11:0];
          kp.x    = pt_x[first[k]];
          kp.y    = pt_y[first[k]];
          kp.z    = pt_z[first[k]];
          kp.last = 1'b0;
          pending = {pending, kp};
          idx_last = pending.size() - 1;
        end
      end
      if (idx_last >= 0) pending[idx_last].last = 1'b1;
    end
    start_cloud();
  endfunction

  function void check_keypoint(bit [11:0] num, bit [31:0] x, bit [31:0] y,
                               bit [31:0] z, bit last);
    keypoint_t e;
    if (pending.size() == 0) begin
      $error("unexpected keypoint: point_number %0d", num);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (num != e.num) begin
      $error("point_number: expected %0d, got %0d", e.num, num);
      errors++;
    end
    if (x != e.x) begin
      $error("out_x: expected %h, got %h", e.x, x);
      errors++;
    end
    if (y != e.y) begin
      $error("out_y: expected %h, got %h", e.y, y);
      errors++;
    end
    if (z != e.z) begin
      $error("out_z: expected %h, got %h", e.z, z);
      errors++;
    end
    if (last != e.last) begin
      $error("last_keypoint: expected %0d, got %0d", e.last, last);
      errors++;
    end
  endfunction
endclass

module grid_cell_first_point_sampler_tb;

  localparam int WATCHDOG_CYCLES = 50000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic signed [31:0] in_coord_x = '0;
  logic signed [31:0] in_coord_y = '0;
  logic signed [31:0] in_coord_z = '0;
  logic               in_last_point = 1'b0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic [11:0]        out_point_number;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               out_last_keypoint;
  logic               cfg_we = 1'b0;
  logic [30:0]        cfg_wdata = '0;

  keypoint_board board = new();
  bit            in_rush;
  bit            out_rush;
  int            points_sent;
  int            cloud_len;
  int            quiet_cycles;

  always #2ns clk = ~clk;

  grid_cell_first_point_sampler i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .in_coord_z        (in_coord_z),
    .in_last_point     (in_last_point),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_point_number  (out_point_number),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_z             (out_z),
    .out_last_keypoint (out_last_keypoint),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst_n && in_push && !in_full)
      board.note_point(in_coord_x, in_coord_y, in_coord_z, in_last_point);
    if (rst_n && out_pop && !out_empty)
      board.check_keypoint(out_point_number, out_x, out_y, out_z, out_last_keypoint);
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_we || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls per keypoint request
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 7) == 0) out_rush = !out_rush;
      stall = out_rush ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(negedge clk); while (out_empty);
      @(posedge clk);
    end
  end

  task automatic send_point(bit [31:0] x, bit [31:0] y, bit [31:0] z, bit last);
    int gap;
    gap = in_rush ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push       <= 1'b1;
    in_coord_x    <= x;
    in_coord_y    <= y;
    in_coord_z    <= z;
    in_last_point <= last;
    do @(negedge clk); while (in_full);
    @(posedge clk);
    points_sent++;
    cloud_len = last ? 0 : cloud_len + 1;
  endtask

  task automatic drain_and_settle(int cloud_pts);
    in_push <= 1'b0;
    @(negedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (cloud_pts + 200) @(posedge clk);
  endtask

  task automatic write_resolution(bit [30:0] value);
    drain_and_settle(4200);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.res = value;
  endtask

  task automatic random_cloud(int npts);
    longint unsigned pitch, span;
    bit [31:0]       bx, by, x, y;
    bit              flat_x;
    pitch = 64'(board.res) * 10;
    span = pitch * $urandom_range(0, 12) + $urandom_range(0, 32'(pitch));
    if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
    bx = $urandom();
    by = $urandom();
    flat_x = ($urandom_range(0, 11) == 0);
    in_rush = ($urandom_range(0, 3) == 0);
    for (int p = 0; p < npts; p++) begin
      x = flat_x ? bx : bx + $urandom_range(0, 32'(span));
      y = by + $urandom_range(0, 32'(span));
      if ($urandom_range(0, 9) == 0) begin
        x = $urandom();
        y = $urandom();
      end
      send_point(x, y, $urandom(), p == npts - 1);
    end
  endtask

  task automatic random_phase(int items);
    int goal;
    goal = points_sent + items;
    while (points_sent < goal) begin
      random_cloud($urandom_range(1, 30));
      if ($urandom_range(0, 4) == 0) drain_and_settle(0);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single point, no grid
    send_point(32'h0000_1234, 32'h0000_5678, 32'h1, 1'b1);
    // full-range corners
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h0, 32'h0, 32'h0, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_AAAA, 1'b1);
    // zero x extent
    send_point(32'h5, 32'h0, 32'h2, 1'b0);
    send_point(32'h5, 32'h0010_0000, 32'h3, 1'b0);
    send_point(32'h5, 32'h0020_0000, 32'h4, 1'b1);
    // a few cells, repeats in the same cell
    send_point(32'h0, 32'h0, 32'h10, 1'b0);
    send_point(32'h0000_0001, 32'h0000_0001, 32'h11, 1'b0);
    send_point(32'h001E_0000, 32'h0014_0000, 32'h12, 1'b0);
    send_point(32'h000A_0000, 32'h0014_0000, 32'h13, 1'b0);
    send_point(32'h001E_0000, 32'h0000_0000, 32'h14, 1'b0);
    send_point(32'hFFFF_FFFF, 32'h000A_0000, 32'h15, 1'b1);

    random_phase(50);
    write_resolution(31'd1);
    random_phase(50);
    write_resolution(31'h7FFF_FFFF);
    random_phase(30);
    write_resolution(31'd3000);
    random_phase(50);
    write_resolution(31'd40000);
    random_phase(50);

    drain_and_settle(0);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
